>>> src/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block.
// Used by the port checker; needs nothing else.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Implication on the same edge, off during reset.
`define MEXP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the following edge, off during reset.
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication on the following edge, checked through reset.
`define MEXP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = $clog2(OPERAND_BITS);
    localparam int TDATA_W      = 8 * ((OPERAND_BITS + 7) / 8);
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

    localparam logic [OPERAND_BITS-1:0] MODULUS_RST  = OPERAND_BITS'(2);
    localparam logic [OPERAND_BITS-1:0] EXPONENT_RST = OPERAND_BITS'(1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,       // take base, exponent, set acc to one
        OP_REDUCE,     // sq = base mod m
        OP_MUL,        // acc = acc * sq mod m
        OP_SHIFT,      // exponent >>= 1
        OP_SHIFT_SQR,  // exponent >>= 1, sq = sq * sq mod m
        OP_OUT         // load the result register
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mul_last;   // multiplier writes its result at this edge
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;   // no exponent bit left above the current one
        logic mod_small;  // modulus below two
    } t_status;

endpackage

>>> src/modexp_dp.sv
// Datapath: configuration registers, operand registers, bit-serial modular multiplier.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [modexp_pkg::OPERAND_BITS-1:0] i_cfg_data,
    input  logic [modexp_pkg::OPERAND_BITS-1:0] i_base,
    input  modexp_pkg::t_cmd                    i_cmd,
    output modexp_pkg::t_status                 o_status,
    output logic [modexp_pkg::OPERAND_BITS-1:0] o_result
);

    localparam int W = modexp_pkg::OPERAND_BITS;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_exponent;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;
    logic [W-1:0] r_out;

    logic [W-1:0]                      r_ma;
    logic [W-1:0]                      r_mb;
    logic [W-1:0]                      r_mr;
    logic [modexp_pkg::CNT_W-1:0]      r_cnt;
    logic                              r_busy;
    logic                              r_dest_acc;

    logic [W:0]   w_mod_x;
    logic [W:0]   w_dbl;
    logic [W:0]   w_dbl_red;
    logic [W:0]   w_sum;
    logic [W-1:0] n_mr;
    logic         w_mod_small;

    assign w_mod_x     = {1'b0, r_modulus};
    assign w_mod_small = (r_modulus[W-1:1] == '0);

    // One multiplier bit per cycle, MSB first: r = 2r + bit*a, kept below m.
    always_comb begin
        w_dbl     = {r_mr, 1'b0};
        w_dbl_red = (w_dbl >= w_mod_x) ? (w_dbl - w_mod_x) : w_dbl;
        w_sum     = w_dbl_red + (r_mb[W-1] ? {1'b0, r_ma} : '0);
        n_mr      = (w_sum >= w_mod_x) ? W'(w_sum - w_mod_x) : w_sum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= modexp_pkg::MODULUS_RST;
            r_exponent <= modexp_pkg::EXPONENT_RST;
            r_busy     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    modexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                    modexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
            if (i_cmd.op == modexp_pkg::OP_REDUCE || i_cmd.op == modexp_pkg::OP_MUL ||
                    i_cmd.op == modexp_pkg::OP_SHIFT_SQR) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mr  <= n_mr;
            r_mb  <= {r_mb[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                if (r_dest_acc) begin
                    r_acc <= n_mr;
                end else begin
                    r_sq <= n_mr;
                end
            end
        end
        unique case (i_cmd.op)
            modexp_pkg::OP_LOAD: begin
                r_base <= i_base;
                r_exp  <= r_exponent;
                r_acc  <= W'(1);
            end
            modexp_pkg::OP_REDUCE: begin
                r_ma       <= W'(1);
                r_mb       <= r_base;
                r_mr       <= '0;
                r_cnt      <= modexp_pkg::CNT_W'(W - 1);
                r_dest_acc <= 1'b0;
            end
            modexp_pkg::OP_MUL: begin
                r_ma       <= r_acc;
                r_mb       <= r_sq;
                r_mr       <= '0;
                r_cnt      <= modexp_pkg::CNT_W'(W - 1);
                r_dest_acc <= 1'b1;
            end
            modexp_pkg::OP_SHIFT: begin
                r_exp <= r_exp >> 1;
            end
            modexp_pkg::OP_SHIFT_SQR: begin
                r_exp      <= r_exp >> 1;
                r_ma       <= r_sq;
                r_mb       <= r_sq;
                r_mr       <= '0;
                r_cnt      <= modexp_pkg::CNT_W'(W - 1);
                r_dest_acc <= 1'b0;
            end
            modexp_pkg::OP_OUT: begin
                r_out <= w_mod_small ? '0 : r_acc;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.mul_last  = r_busy && (r_cnt == '0);
        o_status.exp_zero  = (r_exp == '0);
        o_status.exp_lsb   = r_exp[0];
        o_status.exp_last  = (r_exp[W-1:1] == '0);
        o_status.mod_small = w_mod_small;
    end

    assign o_result = r_out;

endmodule

>>> src/modexp_ctrl.sv
// Controller: square-and-multiply sequencer and result handshake.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  modexp_pkg::t_status i_status,
    output modexp_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RED_WAIT,
        S_BIT,
        S_MUL_WAIT,
        S_NEXT,
        S_SQ_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = modexp_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = modexp_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.mod_small || i_status.exp_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = modexp_pkg::OP_REDUCE;
                    n_state  = S_RED_WAIT;
                end
            end
            S_RED_WAIT: begin
                if (i_status.mul_last) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (i_status.exp_lsb) begin
                    o_cmd.op = modexp_pkg::OP_MUL;
                    n_state  = S_MUL_WAIT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL_WAIT: begin
                if (i_status.mul_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.exp_last) begin
                    o_cmd.op = modexp_pkg::OP_SHIFT;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = modexp_pkg::OP_SHIFT_SQR;
                    n_state  = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (i_status.mul_last) begin
                    n_state = S_BIT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op = modexp_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> src/modular_exponentiation.sv
// Top level of the modular exponentiation block: stream ports and config port.
// Depends on modexp_pkg, modexp_ctrl and modexp_dp.
`timescale 1ns / 1ps

// Computes base^exponent mod modulus for every request, one request at a time,
// with modulus and exponent set through the write port. The user must set them
// only while the block is idle; the block itself does not enforce this. The
// square-and-multiply loop runs on one shared bit-serial modular multiplier, so
// the time a request takes grows with the bit length of the exponent and its
// count of set bits. A zero exponent or a modulus below two gives its answer
// (1 or 0) without the multiplier. The result register lets the next request in
// while the previous result still waits downstream.

module modular_exponentiation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [modexp_pkg::TDATA_W-1:0]      s_axis_tdata,   // [30:0] base
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [modexp_pkg::TDATA_W-1:0]      m_axis_tdata,   // [30:0] result
    input  logic                                i_cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [modexp_pkg::OPERAND_BITS-1:0] i_cfg_data
);

    modexp_pkg::t_cmd                    w_cmd;
    modexp_pkg::t_status                 w_status;
    logic [modexp_pkg::OPERAND_BITS-1:0] w_result;

    modexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    modexp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_base     (s_axis_tdata[modexp_pkg::OPERAND_BITS-1:0]),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign m_axis_tdata = modexp_pkg::TDATA_W'(w_result);

endmodule

>>> src/modexp_checker.sv
// Port checker for the modular exponentiation block, bound to the top level.
// Depends on modexp_pkg and modular_exponentiation_assert.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [modexp_pkg::TDATA_W-1:0]      m_axis_tdata
);

    logic w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    `MEXP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
    `MEXP_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, w_in_acc, !s_axis_tready, "second request taken while one is in work")
    `MEXP_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, w_in_acc, !$rose(m_axis_tvalid), "result raised right after request")
    `MEXP_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
